// File: hw/rtl/slpe_pkg.sv
// ----------------------------------------------------------------------------
// Shortcut local path extractor package
// Types, codes and fixed constants shared by the extractor modules.
// ----------------------------------------------------------------------------
package slpe_pkg;

   // Fixed layout of the shortcut file
   localparam int unsigned HEADER_BYTES      = 76;
   localparam int unsigned INFO_HEADER_BYTES = 24;
   // Last byte of the fixed link-info fields (end of the local path offset)
   localparam int unsigned LAST_FIXED        = 19;
   localparam int unsigned MIN_PATH_OFFSET   = 4;

   localparam logic [31:0] RESERVED_MASK = 32'hF100_0000;
   localparam int unsigned ID_LIST_BIT   = 0;
   localparam int unsigned LINKINFO_BIT  = 1;

   // Class id of a shell link, in file byte order
   localparam logic [7:0] MAGIC_ID [16] = '{
      8'h01, 8'h14, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h46
   };

   typedef enum logic [2:0] {
      PH_HDR,
      PH_HDR_BAD,
      PH_IDSZ,
      PH_IDSKIP,
      PH_INFOSZ,
      PH_BODY,
      PH_DRAIN,
      PH_IDLE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_FAULT = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      FLT_NONE         = 4'd0,
      FLT_TRUNCATED    = 4'd1,
      FLT_HDR_SMALL    = 4'd2,
      FLT_MAGIC        = 4'd3,
      FLT_RESERVED     = 4'd4,
      FLT_NO_LINKINFO  = 4'd5,
      FLT_INFO_SMALL   = 4'd6,
      FLT_NO_VOLUME    = 4'd7,
      FLT_OFFSET_ZERO  = 4'd8,
      FLT_OFFSET_RANGE = 4'd9,
      FLT_NO_TERM      = 4'd10
   } fault_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_end;
   } item_type;

   typedef struct packed {
      logic       has_result;
      kind_type   kind;
      logic [7:0] path_byte;
      fault_type  fault;
   } step_type;

endpackage

// File: hw/rtl/slpe_req_if.sv
// ----------------------------------------------------------------------------
// Shortcut byte request channel
// Valid/ready channel carrying one file byte and its end-of-file mark.
// ----------------------------------------------------------------------------
interface slpe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       file_end;

   modport source (output valid, output data_byte, output file_end, input ready);
   modport sink   (input valid, input data_byte, input file_end, output ready);
endinterface

// File: hw/rtl/slpe_rsp_if.sv
// ----------------------------------------------------------------------------
// Extracted path response channel
// Valid/ready channel carrying path bytes, completion and fault codes.
// ----------------------------------------------------------------------------
interface slpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] path_byte;
   logic [3:0] fault;

   modport source (output valid, output kind, output path_byte, output fault, input ready);
   modport sink   (input valid, input kind, input path_byte, input fault, output ready);
endinterface

// File: hw/rtl/slpe_in_stage.sv
// ----------------------------------------------------------------------------
// Request input register
// Captures one request; releases it to the parser when the response side
// can take its result.
// ----------------------------------------------------------------------------
module slpe_in_stage import slpe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   slpe_req_if.sink    req_if,
   input  logic        out_busy,
   output item_type    item,
   output logic        advance
);

   logic     in_valid_ff, in_valid_in;
   item_type item_ff;
   logic     req_fire;

   assign advance       = in_valid_ff && !out_busy;
   assign req_if.ready  = !in_valid_ff || advance;
   assign req_fire      = req_if.valid && req_if.ready;
   assign item          = item_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.data_byte <= req_if.data_byte;
         item_ff.file_end  <= req_if.file_end;
      end
   end

endmodule

// File: hw/rtl/slpe_parser.sv
// ----------------------------------------------------------------------------
// Shortcut parser
// Holds the parse state and decides the result of one file byte.
// ----------------------------------------------------------------------------
module slpe_parser import slpe_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  item_type item,
   output step_type step
);

   localparam logic [31:0] HDR_LAST = 32'(HEADER_BYTES - 1);

   phase_type   phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] hdr_flags_ff, hdr_flags_in;
   logic [15:0] id_left_ff, id_left_in;
   logic [31:0] info_size_ff, info_size_in;
   logic        vol_flag_ff, vol_flag_in;
   logic [31:0] path_offset_ff, path_offset_in;
   logic        path_ended_ff, path_ended_in;
   logic [7:0]  early_bytes_ff [16];

   logic [7:0]  b;
   logic        fe;
   logic [31:0] size_n;
   logic [31:0] flags_n;
   logic [15:0] id_n;
   logic        vol_n;
   logic [31:0] offset_n;
   logic [4:0]  lag;
   logic [31:0] cursor;
   logic [7:0]  cur_byte;
   logic        cur_zero;
   logic        cur_last;
   logic        at_end;
   logic        cursor_run;
   logic        run_end;
   logic        run_last;
   logic        run_byte;
   fault_type   hdr_fault;
   fault_type   body_fault;

   assign b  = item.data_byte;
   assign fe = item.file_end;

   // Field merges: OR the byte into its lane
   assign size_n  = info_size_ff | (32'(b) << {pos_ff[1:0], 3'b000});
   assign flags_n = hdr_flags_ff | (32'(b) << {pos_ff[1:0], 3'b000});
   assign id_n    = id_left_ff | (16'(b) << {pos_ff[0], 3'b000});

   // Link-info fields as they stand after this byte
   always_comb begin
      vol_n    = vol_flag_ff;
      offset_n = path_offset_ff;
      if (phase_ff == PH_BODY) begin
         if (pos_ff == 32'd8) begin
            vol_n = vol_flag_ff | b[0];
         end
         if (pos_ff >= 32'd16 && pos_ff <= 32'(LAST_FIXED)) begin
            offset_n = path_offset_ff | (32'(b) << {pos_ff[1:0], 3'b000});
         end
      end
   end

   // Lagging read cursor into the ring of recent link-info bytes
   assign lag      = (offset_n < 32'(LAST_FIXED)) ?
                     5'(32'(LAST_FIXED) - offset_n) : 5'd0;
   assign cursor   = pos_ff - 32'(lag);
   assign cur_byte = (phase_ff == PH_BODY && lag == 5'd0) ? b : early_bytes_ff[cursor[3:0]];
   assign cur_zero = cur_byte == 8'h00;
   assign cur_last = cursor == info_size_ff - 32'd1;
   assign at_end   = pos_ff == info_size_ff - 32'd1;

   assign cursor_run = !path_ended_ff && vol_n && offset_n >= 32'(MIN_PATH_OFFSET) &&
                       offset_n < info_size_ff && pos_ff >= 32'(LAST_FIXED) &&
                       pos_ff >= offset_n;
   assign run_end  = cursor_run && cur_zero;
   assign run_last = cursor_run && !cur_zero && cur_last;
   assign run_byte = cursor_run && !cur_zero && !cur_last;

   always_comb begin
      priority if (info_size_ff < 32'(HEADER_BYTES)) begin
         hdr_fault = FLT_HDR_SMALL;
      end else if (phase_ff == PH_HDR_BAD) begin
         hdr_fault = FLT_MAGIC;
      end else if ((hdr_flags_ff & RESERVED_MASK) != 32'd0) begin
         hdr_fault = FLT_RESERVED;
      end else if (!hdr_flags_ff[LINKINFO_BIT]) begin
         hdr_fault = FLT_NO_LINKINFO;
      end else begin
         hdr_fault = FLT_NONE;
      end
   end

   always_comb begin
      priority if (!vol_n) begin
         body_fault = FLT_NO_VOLUME;
      end else if (offset_n == 32'd0) begin
         body_fault = FLT_OFFSET_ZERO;
      end else if (offset_n >= info_size_ff) begin
         body_fault = FLT_OFFSET_RANGE;
      end else begin
         body_fault = FLT_NONE;
      end
   end

   // Result of this byte
   always_comb begin
      step.has_result = 1'b0;
      step.kind       = KIND_BYTE;
      step.path_byte  = 8'h00;
      step.fault      = FLT_NONE;
      unique case (phase_ff)
         PH_HDR, PH_HDR_BAD: begin
            if (pos_ff == HDR_LAST && hdr_fault != FLT_NONE) begin
               step.has_result = 1'b1;
               step.kind       = KIND_FAULT;
               step.fault      = hdr_fault;
            end
         end
         PH_INFOSZ: begin
            if (pos_ff >= 32'd3 && size_n < 32'(INFO_HEADER_BYTES)) begin
               step.has_result = 1'b1;
               step.kind       = KIND_FAULT;
               step.fault      = FLT_INFO_SMALL;
            end
         end
         PH_BODY: begin
            priority if (at_end && body_fault != FLT_NONE) begin
               step.has_result = 1'b1;
               step.kind       = KIND_FAULT;
               step.fault      = body_fault;
            end else if (at_end && offset_n < 32'(MIN_PATH_OFFSET)) begin
               step.has_result = 1'b1;
               step.kind       = KIND_DONE;
            end else if (at_end) begin
               step.has_result = 1'b1;
               priority if (path_ended_ff || run_end) begin
                  step.kind = KIND_DONE;
               end else if (run_last) begin
                  step.kind  = KIND_FAULT;
                  step.fault = FLT_NO_TERM;
               end else begin
                  step.kind      = KIND_BYTE;
                  step.path_byte = run_byte ? cur_byte : 8'h00;
               end
            end else if (run_byte) begin
               step.has_result = 1'b1;
               step.kind       = KIND_BYTE;
               step.path_byte  = cur_byte;
            end else begin
               step.has_result = 1'b0;
            end
         end
         PH_DRAIN: begin
            step.has_result = 1'b1;
            priority if (cur_zero) begin
               step.kind = KIND_DONE;
            end else if (cur_last) begin
               step.kind  = KIND_FAULT;
               step.fault = FLT_NO_TERM;
            end else begin
               step.kind      = KIND_BYTE;
               step.path_byte = cur_byte;
            end
         end
         PH_IDSZ, PH_IDSKIP, PH_IDLE: begin
            step.has_result = 1'b0;
         end
         default: begin
            step.has_result = 1'b0;
         end
      endcase
      // A file that ends before its result is truncated
      if (fe && phase_ff != PH_IDLE && (!step.has_result || step.kind == KIND_BYTE)) begin
         step.has_result = 1'b1;
         step.kind       = KIND_FAULT;
         step.path_byte  = 8'h00;
         step.fault      = FLT_TRUNCATED;
      end
   end

   // Next parse state
   always_comb begin
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      hdr_flags_in   = hdr_flags_ff;
      id_left_in     = id_left_ff;
      info_size_in   = info_size_ff;
      vol_flag_in    = vol_flag_ff;
      path_offset_in = path_offset_ff;
      path_ended_in  = path_ended_ff;
      unique case (phase_ff)
         PH_HDR, PH_HDR_BAD: begin
            if (pos_ff < 32'd4) begin
               info_size_in = size_n;
            end else if (pos_ff < 32'd20) begin
               if (b != MAGIC_ID[pos_ff[3:0] - 4'd4]) begin
                  phase_in = PH_HDR_BAD;
               end
            end else if (pos_ff < 32'd24) begin
               hdr_flags_in = flags_n;
            end
            if (pos_ff == HDR_LAST) begin
               if (hdr_fault == FLT_NONE) begin
                  phase_in     = hdr_flags_ff[ID_LIST_BIT] ? PH_IDSZ : PH_INFOSZ;
                  info_size_in = 32'd0;
                  pos_in       = 32'd0;
               end
            end else begin
               pos_in = pos_ff + 32'd1;
            end
         end
         PH_IDSZ: begin
            id_left_in = id_n;
            if (pos_ff >= 32'd1) begin
               pos_in   = 32'd0;
               phase_in = (id_n != 16'd0) ? PH_IDSKIP : PH_INFOSZ;
            end else begin
               pos_in = 32'd1;
            end
         end
         PH_IDSKIP: begin
            id_left_in = id_left_ff - 16'd1;
            if (id_left_in == 16'd0) begin
               phase_in = PH_INFOSZ;
            end
         end
         PH_INFOSZ: begin
            info_size_in = size_n;
            if (pos_ff >= 32'd3) begin
               phase_in = PH_BODY;
               pos_in   = 32'd4;
            end else begin
               pos_in = pos_ff + 32'd1;
            end
         end
         PH_BODY: begin
            vol_flag_in    = vol_n;
            path_offset_in = offset_n;
            path_ended_in  = path_ended_ff | run_end;
            pos_in         = pos_ff + 32'd1;
            if (at_end) begin
               phase_in = PH_DRAIN;
            end
         end
         PH_DRAIN: begin
            pos_in = pos_ff + 32'd1;
         end
         PH_IDLE: begin
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      // Any completion or fault parks the parser until the file ends
      if (step.has_result && step.kind != KIND_BYTE) begin
         phase_in = PH_IDLE;
      end
      // Rearm for the next file
      if (fe) begin
         phase_in       = PH_HDR;
         pos_in         = 32'd0;
         hdr_flags_in   = 32'd0;
         id_left_in     = 16'd0;
         info_size_in   = 32'd0;
         vol_flag_in    = 1'b0;
         path_offset_in = 32'd0;
         path_ended_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HDR;
         pos_ff         <= 32'd0;
         hdr_flags_ff   <= 32'd0;
         id_left_ff     <= 16'd0;
         info_size_ff   <= 32'd0;
         vol_flag_ff    <= 1'b0;
         path_offset_ff <= 32'd0;
         path_ended_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         hdr_flags_ff   <= hdr_flags_in;
         id_left_ff     <= id_left_in;
         info_size_ff   <= info_size_in;
         vol_flag_ff    <= vol_flag_in;
         path_offset_ff <= path_offset_in;
         path_ended_ff  <= path_ended_in;
      end
   end

   // Keep the last sixteen link-info bytes for the lagging path read
   always_ff @(posedge clock) begin
      if (advance && phase_ff == PH_BODY) begin
         early_bytes_ff[pos_ff[3:0]] <= b;
      end
   end

endmodule

// File: hw/rtl/slpe_rsp_stage.sv
// ----------------------------------------------------------------------------
// Response output register
// Holds one result until the response channel takes it.
// ----------------------------------------------------------------------------
module slpe_rsp_stage import slpe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  step_type    step,
   slpe_rsp_if.source  rsp_if,
   output logic        out_busy
);

   logic       out_valid_ff, out_valid_in;
   kind_type   kind_ff;
   logic [7:0] path_byte_ff;
   fault_type  fault_ff;

   assign out_busy = out_valid_ff && !rsp_if.ready;

   always_comb begin
      if (advance) begin
         out_valid_in = step.has_result;
      end else begin
         out_valid_in = out_busy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff      <= step.kind;
         path_byte_ff <= step.path_byte;
         fault_ff     <= step.fault;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.kind      = kind_ff;
   assign rsp_if.path_byte = path_byte_ff;
   assign rsp_if.fault     = fault_ff;

endmodule

// File: hw/rtl/shortcut_local_path_extractor_top.sv
// ----------------------------------------------------------------------------
// Shortcut local path extractor
// Parses a shortcut file streamed one byte per request and returns the
// local base path bytes, then a completion or a fault code.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload                         meaning
//   req_if    in         data_byte[7:0], file_end        one file byte
//   rsp_if    out        kind[1:0], path_byte[7:0],      path byte, done or
//                        fault[3:0]                      fault, at most one
//                                                        per request
//
// Cycles: one request per clock sustained while responses are taken; an
// accepted request is loaded into the input register, and its response into
// the result register when the parser advances on it.
// The parser update for a byte is a single pass of compares and field
// merges between those two registers, so the rate is set by the handshake.
// Reset: synchronous, clears both registers and the parse state; the first
// byte after reset is header byte zero.
// Stalls: a held response stops the parser; an empty input register still
// takes one request, then req_if.ready drops until the response is taken.
//
module shortcut_local_path_extractor_top import slpe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   slpe_req_if.sink    req_if,
   slpe_rsp_if.source  rsp_if
);

   item_type item;
   logic     advance;
   logic     out_busy;
   step_type step;

   // Hold each request until the result side has room
   slpe_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .out_busy (out_busy),
      .item     (item),
      .advance  (advance)
   );

   // Advance the parse state and decide the result of the held byte
   slpe_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .step    (step)
   );

   // Register the result; drop steps that produce none
   slpe_rsp_stage u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .step     (step),
      .rsp_if   (rsp_if),
      .out_busy (out_busy)
   );

endmodule

// File: hw/rtl/slpe_checker.sv
// ----------------------------------------------------------------------------
// Shortcut extractor port checker
// Watches the response channel for payload and reset rules.
// ----------------------------------------------------------------------------
module slpe_checker import slpe_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_path_byte,
   input logic [3:0] rsp_fault
);

   // A stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_path_byte) && $stable(rsp_fault))
      else $error("response changed while stalled");

   // Fault code is set exactly on fault responses
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_FAULT) == (rsp_fault != FLT_NONE)))
      else $error("fault code does not match response kind");

   // Path byte is zero unless the response carries one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_BYTE |-> rsp_path_byte == 8'h00)
      else $error("path byte set on a non-byte response");

   // Reset empties the response register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind shortcut_local_path_extractor_top slpe_checker u_slpe_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_kind      (rsp_if.kind),
   .rsp_path_byte (rsp_if.path_byte),
   .rsp_fault     (rsp_if.fault)
);

// File: dv/shortcut_local_path_extractor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortcut local path extractor testbench
// Streams whole shortcut files into the extractor: well-formed files with
// random content, each fault in turn, truncated files and raw noise. A
// byte-level parser model predicts every response. A checker compares each
// response field by field, in order, while both sides of the handshake idle
// at random.
// ----------------------------------------------------------------------------
module shortcut_local_path_extractor_top_tb;
   import slpe_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_CYCLES  = 400;

   // Outcome of one read at the lagging path cursor
   typedef enum logic [1:0] {
      CUR_NONE,
      CUR_TERM,
      CUR_BYTE,
      CUR_OVERRUN
   } cursor_type;

   // Layout of one generated shortcut file
   typedef struct {
      logic [31:0] hdr_size;
      bit          bad_magic;
      logic [31:0] link_flags;
      int          id_len;
      logic [31:0] info_size;
      logic [31:0] vol_flags;
      logic [31:0] path_ofs;
      int          path_len;   // path bytes before the terminator, -1 for none
      int          tail_len;
      int          cut_at;     // keep only this many bytes, -1 for the whole file
   } lnk_shape_type;

   logic clock;
   logic reset;

   slpe_req_if req_if ();
   slpe_rsp_if rsp_if ();

   shortcut_local_path_extractor_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Parser model state
   phase_type   prs_phase;
   logic [31:0] sect_pos;
   logic [31:0] lnk_flags;
   logic [15:0] idlist_left;
   logic [31:0] info_len;
   logic [31:0] vol_flags;
   logic [31:0] base_ofs;
   logic [7:0]  info_ring [16];
   logic        path_done;

   step_type   extract_q [$];
   logic [7:0] file_bytes [$];

   int mismatch_count;
   int bytes_sent;
   int req_idle_pct;
   int rsp_idle_pct;
   int hold_request;
   int hold_left;
   int waited;

   // ---------------------------------------------------------------------
   // Clock and watchdog
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("shortcut_local_path_extractor_top: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Parser model
   // ---------------------------------------------------------------------
   function automatic void clear_parser();
      prs_phase   = PH_HDR;
      sect_pos    = '0;
      lnk_flags   = '0;
      idlist_left = '0;
      info_len    = '0;
      vol_flags   = '0;
      base_ofs    = '0;
      path_done   = 1'b0;
      foreach (info_ring[i]) info_ring[i] = 8'h00;
   endfunction

   // Distance the path cursor trails the input while the path overlaps the
   // fixed link-info fields
   function automatic logic [31:0] path_lag();
      return (base_ofs < LAST_FIXED) ? LAST_FIXED - base_ofs : 32'd0;
   endfunction

   function automatic cursor_type read_path_cursor(input logic [31:0] pos,
                                                   output logic [7:0] val);
      logic [31:0] cur;
      cur = pos - path_lag();
      val = info_ring[cur[3:0]];
      if (val == 8'h00) begin
         path_done = 1'b1;
         return CUR_TERM;
      end
      if (cur == info_len - 32'd1) return CUR_OVERRUN;
      return CUR_BYTE;
   endfunction

   // Advance the parser by one file byte; return the response it causes
   function automatic step_type parse_shortcut_byte(input logic [7:0] b, input logic fe);
      step_type    res;
      logic        got;
      logic        was_idle;
      logic        at_end;
      logic        closed;
      logic [31:0] pos;
      logic [31:0] reach;
      logic [7:0]  pb;
      logic [7:0]  val;
      kind_type    kind;
      fault_type   flt;
      cursor_type  cur;

      got      = 1'b0;
      closed   = 1'b0;
      kind     = KIND_BYTE;
      flt      = FLT_NONE;
      pb       = 8'h00;
      val      = 8'h00;
      cur      = CUR_NONE;
      pos      = sect_pos;
      was_idle = (prs_phase == PH_IDLE);

      case (prs_phase)
         PH_HDR, PH_HDR_BAD: begin
            if (pos < 4)
               info_len |= {24'd0, b} << (8 * pos[1:0]);
            else if (pos < 20) begin
               if (b != MAGIC_ID[4'(pos - 32'd4)]) prs_phase = PH_HDR_BAD;
            end else if (pos < 24)
               lnk_flags |= {24'd0, b} << (8 * pos[1:0]);
            if (pos == HEADER_BYTES - 1) begin
               if (info_len < HEADER_BYTES)              flt = FLT_HDR_SMALL;
               else if (prs_phase == PH_HDR_BAD)         flt = FLT_MAGIC;
               else if ((lnk_flags & RESERVED_MASK) != 0) flt = FLT_RESERVED;
               else if (!lnk_flags[LINKINFO_BIT])        flt = FLT_NO_LINKINFO;
               if (flt != FLT_NONE) begin
                  got       = 1'b1;
                  kind      = KIND_FAULT;
                  prs_phase = PH_IDLE;
               end else begin
                  prs_phase = lnk_flags[ID_LIST_BIT] ? PH_IDSZ : PH_INFOSZ;
                  info_len  = '0;
                  sect_pos  = '0;
               end
            end else begin
               sect_pos = pos + 32'd1;
            end
         end
         PH_IDSZ: begin
            idlist_left |= {8'd0, b} << (8 * pos[0]);
            if (pos >= 1) begin
               sect_pos  = '0;
               prs_phase = (idlist_left != 0) ? PH_IDSKIP : PH_INFOSZ;
            end else begin
               sect_pos = 32'd1;
            end
         end
         PH_IDSKIP: begin
            idlist_left = idlist_left - 16'd1;
            if (idlist_left == 0) prs_phase = PH_INFOSZ;
         end
         PH_INFOSZ: begin
            info_len |= {24'd0, b} << (8 * pos[1:0]);
            if (pos >= 3) begin
               if (info_len < INFO_HEADER_BYTES) begin
                  got       = 1'b1;
                  kind      = KIND_FAULT;
                  flt       = FLT_INFO_SMALL;
                  prs_phase = PH_IDLE;
               end else begin
                  prs_phase = PH_BODY;
                  sect_pos  = 32'd4;
               end
            end else begin
               sect_pos = pos + 32'd1;
            end
         end
         PH_BODY: begin
            at_end = (pos == info_len - 32'd1);
            info_ring[pos[3:0]] = b;
            if (pos >= 8 && pos <= 11)
               vol_flags |= {24'd0, b} << (8 * pos[1:0]);
            else if (pos >= 16 && pos <= LAST_FIXED)
               base_ofs |= {24'd0, b} << (8 * pos[1:0]);
            if (at_end) begin
               if (!vol_flags[0])            flt = FLT_NO_VOLUME;
               else if (base_ofs == 0)       flt = FLT_OFFSET_ZERO;
               else if (base_ofs >= info_len) flt = FLT_OFFSET_RANGE;
               if (flt != FLT_NONE) begin
                  got       = 1'b1;
                  kind      = KIND_FAULT;
                  prs_phase = PH_IDLE;
                  closed    = 1'b1;
               end else if (base_ofs < MIN_PATH_OFFSET) begin
                  // Offsets in the size field: empty path
                  got       = 1'b1;
                  kind      = KIND_DONE;
                  prs_phase = PH_IDLE;
                  closed    = 1'b1;
               end
            end
            if (!closed) begin
               reach = base_ofs + path_lag();
               if (!path_done && vol_flags[0] && base_ofs >= MIN_PATH_OFFSET &&
                   base_ofs < info_len && pos >= LAST_FIXED && pos >= reach)
                  cur = read_path_cursor(pos, val);
               if (cur == CUR_BYTE) pb = val;
               if (at_end) begin
                  got = 1'b1;
                  if (path_done) begin
                     kind      = KIND_DONE;
                     prs_phase = PH_IDLE;
                  end else if (cur == CUR_OVERRUN) begin
                     kind      = KIND_FAULT;
                     flt       = FLT_NO_TERM;
                     prs_phase = PH_IDLE;
                  end else begin
                     kind      = KIND_BYTE;
                     prs_phase = PH_DRAIN;
                  end
               end else if (cur == CUR_BYTE) begin
                  got  = 1'b1;
                  kind = KIND_BYTE;
               end
               sect_pos = pos + 32'd1;
            end
         end
         PH_DRAIN: begin
            // Clock out the lagging path on the bytes after the block
            cur = read_path_cursor(pos, val);
            got = 1'b1;
            if (cur == CUR_TERM) begin
               kind      = KIND_DONE;
               prs_phase = PH_IDLE;
            end else if (cur == CUR_OVERRUN) begin
               kind      = KIND_FAULT;
               flt       = FLT_NO_TERM;
               prs_phase = PH_IDLE;
            end else begin
               kind = KIND_BYTE;
               pb   = val;
            end
            sect_pos = pos + 32'd1;
         end
         default: ;
      endcase

      // End of file: report truncation unless a verdict is already out, rearm
      if (fe) begin
         if (!was_idle && (!got || kind == KIND_BYTE)) begin
            got  = 1'b1;
            kind = KIND_FAULT;
            flt  = FLT_TRUNCATED;
         end
         clear_parser();
      end

      res.has_result = got;
      res.kind       = kind;
      res.path_byte  = (kind == KIND_BYTE) ? pb : 8'h00;
      res.fault      = (kind == KIND_FAULT) ? flt : FLT_NONE;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Request monitor: predict on every accepted request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : predict_requests
      step_type want;
      if (!reset && req_if.valid && req_if.ready) begin
         want = parse_shortcut_byte(req_if.data_byte, req_if.file_end);
         if (want.has_result) extract_q.push_back(want);
      end
   end

   // ---------------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------------
   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_responses
      step_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (extract_q.size() == 0) begin
            flag_mismatch("unexpected response, kind", rsp_if.kind, 0);
         end else begin
            want = extract_q.pop_front();
            if (rsp_if.kind != want.kind)
               flag_mismatch("kind", rsp_if.kind, want.kind);
            if (rsp_if.path_byte != want.path_byte)
               flag_mismatch("path_byte", rsp_if.path_byte, want.path_byte);
            if (rsp_if.fault != want.fault)
               flag_mismatch("fault", rsp_if.fault, want.fault);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response ready: random idling, plus a long hold-off on demand
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_ready
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic fe);
      // Idle before offering the byte, then hold it until taken
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.file_end  <= fe;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_file();
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
   endtask

   // ---------------------------------------------------------------------
   // File generation
   // ---------------------------------------------------------------------
   function automatic lnk_shape_type good_shape();
      lnk_shape_type s;
      s.hdr_size   = ($urandom_range(3) == 0) ? $urandom_range(32'hFFFF_FFFF, HEADER_BYTES)
                                              : HEADER_BYTES;
      s.bad_magic  = 1'b0;
      s.link_flags = ($urandom() & ~RESERVED_MASK) | (32'd1 << LINKINFO_BIT);
      s.id_len     = $urandom_range(12);
      s.info_size  = $urandom_range(48, INFO_HEADER_BYTES);
      s.vol_flags  = $urandom() | 32'd1;
      case ($urandom_range(9))
         8:       s.path_ofs = $urandom_range(MIN_PATH_OFFSET - 1, 1);
         6, 7:    s.path_ofs = $urandom_range(LAST_FIXED, MIN_PATH_OFFSET);
         default: s.path_ofs = $urandom_range(s.info_size - 1, LAST_FIXED + 1);
      endcase
      s.path_len = $urandom_range(s.info_size - 1 - s.path_ofs);
      s.tail_len = $urandom_range(20);
      s.cut_at   = -1;
      return s;
   endfunction

   // Bend a good layout so that the parser must stop with the given fault
   function automatic lnk_shape_type with_fault(input lnk_shape_type s, input fault_type f);
      case (f)
         FLT_TRUNCATED:   s.cut_at = $urandom_range(140, 1);
         FLT_HDR_SMALL:   s.hdr_size = $urandom_range(HEADER_BYTES - 1);
         FLT_MAGIC:       s.bad_magic = 1'b1;
         FLT_RESERVED:
            s.link_flags[($urandom_range(4) == 0) ? 24 : $urandom_range(31, 28)] = 1'b1;
         FLT_NO_LINKINFO: s.link_flags[LINKINFO_BIT] = 1'b0;
         FLT_INFO_SMALL:  s.info_size = $urandom_range(INFO_HEADER_BYTES - 1);
         FLT_NO_VOLUME:   s.vol_flags[0] = 1'b0;
         FLT_OFFSET_ZERO: s.path_ofs = '0;
         FLT_OFFSET_RANGE: s.path_ofs = $urandom_range(32'hFFFF_FFFF, s.info_size);
         FLT_NO_TERM: begin
            s.path_ofs = $urandom_range(s.info_size - 1, LAST_FIXED + 1);
            s.path_len = -1;
         end
         default: ;
      endcase
      return s;
   endfunction

   function automatic void build_shortcut(input lnk_shape_type s);
      logic [7:0] info [$];
      int body_len;
      int ofs;
      file_bytes.delete();
      for (int i = 0; i < 4; i++) file_bytes.push_back(s.hdr_size[8*i +: 8]);
      for (int i = 0; i < 16; i++) file_bytes.push_back(MAGIC_ID[i]);
      if (s.bad_magic) file_bytes[4 + $urandom_range(15)] ^= 8'(1 << $urandom_range(7));
      for (int i = 0; i < 4; i++) file_bytes.push_back(s.link_flags[8*i +: 8]);
      while (file_bytes.size() < HEADER_BYTES) file_bytes.push_back(8'($urandom()));
      if (s.link_flags[ID_LIST_BIT]) begin
         file_bytes.push_back(s.id_len[7:0]);
         file_bytes.push_back(s.id_len[15:8]);
         repeat (s.id_len) file_bytes.push_back(8'($urandom()));
      end
      // Cap huge blocks; the file then ends inside the block
      body_len = (s.info_size <= 400) ? int'(s.info_size) : 64;
      if (body_len < 4) body_len = 4;
      repeat (body_len) info.push_back(8'($urandom()));
      for (int i = 0; i < 4; i++) begin
         info[i] = s.info_size[8*i +: 8];
         if (8 + i < body_len)  info[8 + i]  = s.vol_flags[8*i +: 8];
         if (16 + i < body_len) info[16 + i] = s.path_ofs[8*i +: 8];
      end
      // Path text past the fixed fields; inside them the fields are the path
      if (s.path_ofs < body_len) begin
         ofs = int'(s.path_ofs);
         for (int q = ofs; q < body_len; q++) begin
            if (q > LAST_FIXED)
               info[q] = (s.path_len < 0 || q - ofs < s.path_len) ?
                         8'($urandom_range(255, 1)) : 8'h00;
            if (q - ofs == s.path_len) break;
         end
      end
      foreach (info[i]) file_bytes.push_back(info[i]);
      repeat (s.tail_len) file_bytes.push_back(8'($urandom()));
      if (s.cut_at > 0)
         while (file_bytes.size() > s.cut_at) void'(file_bytes.pop_back());
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_local_paths();
      lnk_shape_type s;
      // Long path well after the fixed fields, with an ID list
      s = good_shape();
      s.link_flags[ID_LIST_BIT] = 1'b1;
      s.id_len    = 9;
      s.info_size = 64;
      s.path_ofs  = 24;
      s.path_len  = 30;
      build_shortcut(s);
      send_file();
      // Widest lag: path at offset 4, drained over the trailing bytes
      s = good_shape();
      s.vol_flags = 32'hFFFF_FFFF;
      s.info_size = INFO_HEADER_BYTES;
      s.path_ofs  = MIN_PATH_OFFSET;
      s.tail_len  = 20;
      build_shortcut(s);
      send_file();
      // Path starting on the last fixed byte, no lag
      s = good_shape();
      s.path_ofs = LAST_FIXED;
      build_shortcut(s);
      send_file();
      // Empty paths: offsets inside the size field, and a bare terminator
      for (int ofs = 1; ofs < MIN_PATH_OFFSET; ofs++) begin
         s = good_shape();
         s.path_ofs = ofs;
         build_shortcut(s);
         send_file();
      end
      s = good_shape();
      s.path_ofs = LAST_FIXED + 1;
      s.path_len = 0;
      build_shortcut(s);
      send_file();
      // Extreme header size, ID list flagged but empty, file ends on the last block byte
      s = good_shape();
      s.hdr_size = 32'hFFFF_FFFF;
      s.link_flags = ~RESERVED_MASK;
      s.id_len   = 0;
      s.tail_len = 0;
      s.path_ofs = 32;
      s.info_size = 40;
      s.path_len = 5;
      build_shortcut(s);
      send_file();
   endtask

   task automatic test_header_faults();
      for (int f = FLT_HDR_SMALL; f <= FLT_NO_LINKINFO; f++) begin
         build_shortcut(with_fault(good_shape(), fault_type'(f)));
         send_file();
      end
   endtask

   task automatic test_info_faults();
      lnk_shape_type s;
      for (int f = FLT_INFO_SMALL; f <= FLT_NO_TERM; f++) begin
         build_shortcut(with_fault(good_shape(), fault_type'(f)));
         send_file();
      end
      // Offset at the top of its range
      s = good_shape();
      s.path_ofs = 32'hFFFF_FFFF;
      build_shortcut(s);
      send_file();
   endtask

   task automatic test_truncation();
      lnk_shape_type s;
      int            cut_points [5];
      // Cut in the header, the ID list and the body
      cut_points = '{1, 40, HEADER_BYTES + 1, HEADER_BYTES + 5, HEADER_BYTES + 20};
      s = good_shape();
      s.link_flags[ID_LIST_BIT] = 1'b1;
      s.id_len = 10;
      foreach (cut_points[i]) begin
         s.cut_at = cut_points[i];
         build_shortcut(s);
         send_file();
      end
      // Cut while the lagging path drains
      s = good_shape();
      s.vol_flags = 32'hFFFF_FFFF;
      s.path_ofs  = MIN_PATH_OFFSET;
      s.link_flags[ID_LIST_BIT] = 1'b0;
      s.tail_len  = 2;
      build_shortcut(s);
      send_file();
      // Block size at the top of its range
      s = good_shape();
      s.info_size = 32'hFFFF_FFFF;
      build_shortcut(s);
      send_file();
   endtask

   task automatic test_ignored_bytes();
      lnk_shape_type s;
      // Drop bytes after a verdict until the end of the file
      s = with_fault(good_shape(), FLT_MAGIC);
      s.tail_len = 30;
      build_shortcut(s);
      send_file();
      // Raw noise
      file_bytes.delete();
      repeat ($urandom_range(90, 1)) file_bytes.push_back(8'($urandom()));
      send_file();
   endtask

   task automatic test_backpressure();
      lnk_shape_type s;
      // Hold off responses while a long path streams in, so the block stalls
      s = good_shape();
      s.link_flags[ID_LIST_BIT] = 1'b0;
      s.info_size = 255;
      s.path_ofs  = 24;
      s.path_len  = 200;
      build_shortcut(s);
      hold_request = HOLD_CYCLES;
      send_file();
   endtask

   task automatic test_random(input int budget);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         case ($urandom_range(9))
            0: begin
               file_bytes.delete();
               repeat ($urandom_range(90, 1)) file_bytes.push_back(8'($urandom()));
            end
            1, 2: build_shortcut(with_fault(good_shape(),
                                            fault_type'($urandom_range(FLT_NO_TERM, 1))));
            default: build_shortcut(good_shape());
         endcase
         send_file();
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = 8'h00;
      req_if.file_end  = 1'b0;
      rsp_if.ready     = 1'b0;
      mismatch_count   = 0;
      bytes_sent       = 0;
      hold_request     = 0;
      hold_left        = 0;
      req_idle_pct     = 15;
      rsp_idle_pct     = 56;
      clear_parser();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_local_paths();
      test_header_faults();
      test_info_faults();
      test_truncation();
      test_ignored_bytes();
      test_random(400);

      req_idle_pct = 56;
      rsp_idle_pct = 15;
      test_random(400);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_backpressure();
      test_random(350);

      // Drain the outstanding responses, then let the pipeline settle
      req_if.valid <= 1'b0;
      waited = 0;
      while (extract_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (extract_q.size() != 0) flag_mismatch("responses still owed", 0, extract_q.size());

      if (mismatch_count == 0) begin
         $display("shortcut_local_path_extractor_top: match");
      end else begin
         $display("shortcut_local_path_extractor_top: mismatch");
      end
      $finish;
   end

endmodule
